[rtl/core/bal_pkg.sv]
// Shared widths, defaults and codes for the bounded array list.
package bal_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int WORD_WIDTH_DEF = 32;

    localparam int OPCODE_W   = 3;
    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 4;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_UPDATE     = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADPOS = 2'd3
    } status_t;

endpackage

[rtl/core/bal_if.sv]
// Valid/ready channel interfaces for list commands and list responses.
interface bal_cmd_if import bal_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [OPCODE_W-1:0]          opcode;
    logic signed [VALUE_W-1:0]    value;
    logic [POSITION_W-1:0]        position;

    modport source (output valid, opcode, value, position, input ready);
    modport sink   (input valid, opcode, value, position, output ready);
endinterface

interface bal_rsp_if import bal_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [STATUS_W-1:0]          status;
    logic signed [VALUE_W-1:0]    popped;
    logic [COUNT_W-1:0]           count;

    modport source (output valid, status, popped, count, input ready);
    modport sink   (input valid, status, popped, count, output ready);
endinterface

[rtl/core/bounded_array_list_core.sv]
// Bounded list of signed words kept in a circular memory with a front pointer.
//
//  channel | role | payload                   | one item means
//  --------+------+---------------------------+-------------------------------
//  cmd     | sink | opcode, value, position   | one list operation
//  rsp     | src  | status, popped, count     | the outcome of that operation
//
// Every operation except a successful pop back answers at once: the command is
// accepted and its response is registered at the same edge. A successful pop
// back first loads the read data register of the entry memory, and its response
// is then registered from the read state. Reset clears the entry count, front
// pointer, state and output valid; the entry memory is not cleared, and only
// entries that were written are ever read. A stalled response holds in the output
// register; a new command is taken in the cycle that the pending response leaves.
module bounded_array_list_core import bal_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bal_cmd_if.sink    cmd,
    bal_rsp_if.source  rsp
);

    // Pointer into the memory, count of held entries, and a width wide enough
    // to compare the count against the position field.
    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       held_reg, held_next;
    logic [PTR_W-1:0]       front_reg, front_next;
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    status_reg;
    logic signed [VALUE_W-1:0] popped_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [WORD_WIDTH-1:0]  rd_data_reg;

    // The entry store: one write or one read per cycle, registered read data.
    logic [WORD_WIDTH-1:0]  entries_mem [CAPACITY];

    logic                   accept;
    logic                   is_full;
    logic                   is_empty;
    logic [CMP_W-1:0]       held_cmp;
    logic [CMP_W-1:0]       pos_cmp;
    logic [PTR_W-1:0]       offset;
    logic [PTR_W:0]         slot_sum;
    logic [PTR_W-1:0]       slot;
    logic [PTR_W-1:0]       front_dec;
    logic [PTR_W-1:0]       front_inc;
    logic signed [63:0]     value_wide;
    logic [WORD_WIDTH-1:0]  wr_word;
    logic signed [WORD_WIDTH-1:0] rd_signed;
    logic signed [63:0]     rd_wide;
    logic                   mem_we;
    logic                   mem_re;
    logic [PTR_W-1:0]       mem_addr;
    status_t                status_d;

    // A command is taken only when no pop is waiting on the memory and the
    // output register is empty or being emptied in this cycle.
    assign cmd.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = cmd.valid && cmd.ready;

    assign is_full  = (held_reg == CNT_W'(CAPACITY));
    assign is_empty = (held_reg == '0);
    assign held_cmp = CMP_W'(held_reg);
    assign pos_cmp  = CMP_W'(cmd.position);

    // The incoming word is sign-extended and then cut to the stored width.
    assign value_wide = 64'(cmd.value);
    assign wr_word    = value_wide[WORD_WIDTH-1:0];

    // Offset from the front for the slot that the operation touches. Each
    // choice is below CAPACITY whenever the operation goes ahead.
    always_comb
    begin
        unique case (cmd.opcode)
            OP_PUSH_BACK: offset = held_reg[PTR_W-1:0];
            OP_POP_BACK:  offset = PTR_W'(held_reg - CNT_W'(1));
            default:      offset = pos_cmp[PTR_W-1:0];
        endcase
    end

    // Circular slot index: one compare and subtract, since the sum stays
    // below twice the capacity.
    assign slot_sum = {1'b0, front_reg} + {1'b0, offset};
    assign slot     = (slot_sum >= (PTR_W + 1)'(CAPACITY))
                    ? PTR_W'(slot_sum - (PTR_W + 1)'(CAPACITY))
                    : slot_sum[PTR_W-1:0];

    assign front_dec = (front_reg == '0) ? PTR_W'(CAPACITY - 1)
                                         : PTR_W'(front_reg - PTR_W'(1));
    assign front_inc = (front_reg == PTR_W'(CAPACITY - 1)) ? '0
                                         : PTR_W'(front_reg + PTR_W'(1));

    // Decode of one command: status, new count and pointer, memory access.
    always_comb
    begin
        status_d   = STAT_OK;
        held_next  = held_reg;
        front_next = front_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = slot;
        if (accept)
        begin
            unique case (cmd.opcode)
                OP_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_d = STAT_FULL;
                    end
                    else
                    begin
                        front_next = front_dec;
                        mem_addr   = front_dec;
                        mem_we     = 1'b1;
                        held_next  = CNT_W'(held_reg + CNT_W'(1));
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_d = STAT_FULL;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        held_next = CNT_W'(held_reg + CNT_W'(1));
                    end
                end
                OP_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_d = STAT_EMPTY;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        held_next = CNT_W'(held_reg - CNT_W'(1));
                    end
                end
                OP_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_d = STAT_EMPTY;
                    end
                    else
                    begin
                        front_next = front_inc;
                        held_next  = CNT_W'(held_reg - CNT_W'(1));
                    end
                end
                OP_UPDATE:
                begin
                    priority if (is_empty)
                    begin
                        status_d = STAT_EMPTY;
                    end
                    else if (pos_cmp >= held_cmp)
                    begin
                        status_d = STAT_BADPOS;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                end
                default:
                begin
                    status_d = STAT_OK;
                end
            endcase
        end
    end

    // Control: a successful pop back waits in the read state for the memory read,
    // and no other command is taken meanwhile, so no access can overlap it.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rsp.ready)
                begin
                    out_valid_next = 1'b0;
                end
                if (accept)
                begin
                    if (mem_re)
                    begin
                        state_next     = ST_READ;
                        out_valid_next = 1'b0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            front_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            front_reg     <= front_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Entry memory with its registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entries_mem[mem_addr] <= wr_word;
        end
        if (mem_re)
        begin
            rd_data_reg <= entries_mem[mem_addr];
        end
    end

    assign rd_signed = rd_data_reg;
    assign rd_wide   = 64'(rd_signed);

    // Response payload. Status and count are written when the command is
    // taken; a successful pop back fills in the word in the following cycle, from the read state.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_d;
            count_reg  <= COUNT_W'(held_next);
            popped_reg <= '0;
        end
        else if (state_reg == ST_READ)
        begin
            popped_reg <= rd_wide[VALUE_W-1:0];
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = status_reg;
    assign rsp.popped = popped_reg;
    assign rsp.count  = count_reg;

endmodule

[rtl/core/bal_checker.sv]
// Port-level assertions for the bounded array list, bound to the list core.
module bal_checker import bal_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cmd_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [STATUS_W-1:0]        rsp_status,
    input logic signed [VALUE_W-1:0]  rsp_popped,
    input logic [COUNT_W-1:0]         rsp_count
);

    // A response that is refused stays unchanged in the next cycle.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_popped) && $stable(rsp_count))
        else $error("response changed while stalled");

    // No command is taken while a response waits and is refused.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !cmd_ready)
        else $error("command taken over a stalled response");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == STAT_FULL |-> rsp_count == COUNT_W'(CAPACITY))
        else $error("full status with a list that is not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == STAT_EMPTY |-> rsp_count == '0)
        else $error("empty status with a list that is not empty");

    a_popped_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_popped != '0 |-> rsp_status == STAT_OK)
        else $error("popped word on a failed operation");

endmodule

bind bounded_array_list_core bal_checker #(
    .CAPACITY (CAPACITY)
) u_bal_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_popped (rsp.popped),
    .rsp_count  (rsp.count)
);

[tb/list_checker.sv]
// Scoreboard for the bounded array list: mirrors the list contents and checks every response.
`timescale 1ns / 100ps

module list_checker import bal_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic clk,
    input  logic rst_n,
    bal_cmd_if   cmd,
    bal_rsp_if   rsp,
    output int   fail_count,
    output int   pending,
    output int   checked
);

    typedef struct {
        status_t                   status;
        logic signed [VALUE_W-1:0] popped;
        logic [COUNT_W-1:0]        count;
    } list_outcome_t;

    // Mirror of the list, front entry at index 0.
    logic signed [VALUE_W-1:0] list_words[$];
    // Outcomes of accepted commands that have not been answered yet, oldest first.
    list_outcome_t             outcomes_due[$];
    list_outcome_t             want;

    // Applies one command to the mirror and returns the response it should produce.
    function automatic list_outcome_t apply_op(
        input logic [OPCODE_W-1:0]   op,
        input logic signed [VALUE_W-1:0] word,
        input logic [POSITION_W-1:0] pos
    );
        list_outcome_t o;
        o.status = STAT_OK;
        o.popped = '0;
        case (op)
            OP_PUSH_FRONT:
                if (list_words.size() >= CAPACITY) o.status = STAT_FULL;
                else list_words.push_front(word);
            OP_PUSH_BACK:
                if (list_words.size() >= CAPACITY) o.status = STAT_FULL;
                else list_words.push_back(word);
            OP_POP_BACK:
                if (list_words.size() == 0) o.status = STAT_EMPTY;
                else o.popped = list_words.pop_back();
            OP_POP_FRONT:
                if (list_words.size() == 0) o.status = STAT_EMPTY;
                else void'(list_words.pop_front());
            OP_UPDATE:
                if (list_words.size() == 0) o.status = STAT_EMPTY;
                else if (pos >= list_words.size()) o.status = STAT_BADPOS;
                else list_words[pos] = word;
            default:
                ;
        endcase
        o.count = COUNT_W'(list_words.size());
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_words.delete();
            outcomes_due.delete();
            fail_count = 0;
            checked = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                checked++;
                if (outcomes_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: response with none due: status %0d popped %0d count %0d",
                             $time, rsp.status, rsp.popped, rsp.count);
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        fail_count++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, rsp.status);
                    end
                    if (rsp.popped !== want.popped)
                    begin
                        fail_count++;
                        $display("%0t: popped mismatch: expected %0d, actual %0d",
                                 $time, want.popped, rsp.popped);
                    end
                    if (rsp.count !== want.count)
                    begin
                        fail_count++;
                        $display("%0t: count mismatch: expected %0d, actual %0d",
                                 $time, want.count, rsp.count);
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                outcomes_due.push_back(apply_op(cmd.opcode, cmd.value, cmd.position));
        end
        pending = outcomes_due.size();
    end

endmodule

[tb/tb_top.sv]
// Top of the bounded array list testbench: clock, reset, command traffic and verdict.
`timescale 1ns / 100ps

module tb_top;
    import bal_pkg::*;

    // Opcodes past the last defined one; the block must treat them as no-ops.
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = OPCODE_W'(OP_UPDATE + 1);
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = '1;

    // Cycles without any accepted item before the run is declared hung. The
    // longest legitimate quiet stretch is the deliberate output hold below,
    // plus a few random gaps, so this leaves a wide margin.
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;

    localparam logic signed [VALUE_W-1:0] CORNER_WORDS [4] = '{
        32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bal_cmd_if cmd ();
    bal_rsp_if rsp ();

    int fail_count;
    int pending;
    int checked;

    // Knobs for the current phase, in percent.
    int send_idle_pct = 0;
    int rx_stall_pct  = 0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    int rx_hold_req   = 0;
    int sent_total    = 0;
    int quiet_cycles  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    bounded_array_list_core #(
        .CAPACITY   (CAPACITY_DEF),
        .WORD_WIDTH (WORD_WIDTH_DEF)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    list_checker #(
        .CAPACITY (CAPACITY_DEF)
    ) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // Every block input starts at a known value before the first edge.
    initial
    begin
        cmd.valid    = 1'b0;
        cmd.opcode   = OP_PUSH_BACK;
        cmd.value    = '0;
        cmd.position = '0;
        rsp.ready    = 1'b0;
    end

    // Response side. Normally ready is random per the phase's stall rate; when
    // the stimulus asks for a hold-off, this process keeps ready low for the
    // requested number of cycles, counting them itself.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req > 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                rsp.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Hang detection: nothing accepted on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic logic signed [VALUE_W-1:0] pick_word();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return CORNER_WORDS[r];
        return $urandom;
    endfunction

    // Offers one command, with random idle cycles ahead of it per the phase,
    // and returns at the edge where the block takes it. Valid is only lowered
    // by a following gap or at the very end, so back-to-back items keep it high.
    task automatic send_cmd(
        input logic [OPCODE_W-1:0]       op,
        input logic signed [VALUE_W-1:0] word,
        input logic [POSITION_W-1:0]     pos
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid    <= 1'b1;
        cmd.opcode   <= op;
        cmd.value    <= word;
        cmd.position <= pos;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        sent_total++;
    endtask

    // Random traffic in bursts of 40 items. Each burst leans either toward
    // pushing or toward popping, so the list keeps swinging between full and
    // empty and the full, empty and bad-position paths all get exercised with
    // the circular front pointer at many different offsets.
    task automatic run_random(input int n_items);
        int push_pct;
        int r;
        logic [OPCODE_W-1:0] op;
        push_pct = 50;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 40 == 0)
                push_pct = $urandom_range(1) ? 70 : 25;
            r = $urandom_range(99);
            if (r < 3)
                op = OPCODE_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
            else if (r < 3 + push_pct)
                op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else
            begin
                case ($urandom_range(2))
                    0:       op = OP_POP_BACK;
                    1:       op = OP_POP_FRONT;
                    default: op = OP_UPDATE;
                endcase
            end
            send_cmd(op, pick_word(), POSITION_W'($urandom_range((1 << POSITION_W) - 1)));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling. Start on the empty list: both pops and an
        // update must report empty, and a spare opcode must change nothing.
        send_cmd(OP_POP_BACK, CORNER_WORDS[0], '0);
        send_cmd(OP_POP_FRONT, CORNER_WORDS[1], '0);
        send_cmd(OP_UPDATE, CORNER_WORDS[0], '0);
        send_cmd(OP_SPARE_HI, CORNER_WORDS[1], '1);

        // Fill to capacity from both ends, extreme words first, so the front
        // pointer wraps below zero while the back runs forward.
        for (int i = 0; i < CAPACITY_DEF; i++)
            send_cmd(i % 2 ? OP_PUSH_BACK : OP_PUSH_FRONT,
                     i < 4 ? CORNER_WORDS[i] : pick_word(), POSITION_W'(i));

        // Pushes on a full list are refused at either end.
        send_cmd(OP_PUSH_FRONT, 32'sd1, '0);
        send_cmd(OP_PUSH_BACK, CORNER_WORDS[3], '0);

        // Updates at the last and first positions, then pop the most negative
        // word back out so its sign survives the round trip.
        send_cmd(OP_UPDATE, CORNER_WORDS[1], '1);
        send_cmd(OP_UPDATE, CORNER_WORDS[0], '0);
        send_cmd(OP_POP_BACK, '0, '0);

        // The last position is now one past the end and must be rejected.
        send_cmd(OP_UPDATE, CORNER_WORDS[2], '1);
        send_cmd(OP_POP_FRONT, '0, '0);
        send_cmd(OP_SPARE_LO, CORNER_WORDS[3], '0);
        send_cmd(OPCODE_W'(OP_SPARE_LO + 1), CORNER_WORDS[0], '1);

        // Random part, one phase per idling pattern.
        run_random(100);

        send_idle_pct = 69;
        run_random(100);

        send_idle_pct = 0;
        rx_stall_pct  = 69;
        run_random(100);

        send_idle_pct = 18;
        rx_stall_pct  = 18;
        run_random(100);

        // Back pressure: the receiver holds ready low for a long stretch while
        // items keep coming, so the held response blocks the command side.
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        rx_hold_req   = HOLD_CYCLES;
        run_random(30);
        cmd.valid <= 1'b0;

        // Drain: let the last accepted item be counted, then wait for every
        // response and wait on for a stray extra one.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Ran %0d list operations through empty, full, bad-position and spare-opcode",
                 sent_total);
        $display("cases under several idle/stall mixes and a long output hold; %0d responses checked.",
                 checked);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
